// ----- hdl/cte_pkg.sv -----
package cte_pkg;

    localparam int BUCKETS   = 256;
    localparam int CAPACITY  = 4096;
    localparam int REF_BIAS  = 32768;

    localparam int REF_W     = 16;
    localparam int BUCKET_AW = $clog2(BUCKETS);
    localparam int ENTRY_AW  = $clog2(CAPACITY);
    localparam int COUNT_W   = $clog2(CAPACITY + 1);

    localparam logic [REF_W-1:0] NIL_REF = '0;

    localparam logic FUNC_EMIT      = 1'b0;
    localparam logic FUNC_NEW_TRACE = 1'b1;

    typedef struct packed {
        logic [6:0]       opcode;
        logic [3:0]       rtype;
        logic [REF_W-1:0] operand_a;
        logic [REF_W-1:0] operand_b;
        logic [REF_W-1:0] link;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_CMP,
        S_APPEND,
        S_DONE
    } state_t;

    function automatic logic [BUCKET_AW-1:0] bucket_of(
        input logic [6:0]       op,
        input logic [REF_W-1:0] a,
        input logic [REF_W-1:0] b
    );
        logic [31:0] v;
        v = {9'b0, op, 16'b0} ^ {8'b0, a, 8'b0} ^ {16'b0, b};
        return v[BUCKET_AW-1:0];
    endfunction

endpackage

// ----- hdl/cse_instruction_table_top.sv -----
// Deduplicating instruction store. An emit transaction either returns the
// reference of an identical earlier instruction (same opcode and operands)
// or appends a new one at reference REF_BIAS + count; a full store answers
// with reference 0 and store_full. A new-trace transaction empties the store
// (bucket heads carry valid bits, cleared together). One item is worked on
// at a time: a dedup emit reads its bucket head in S_HEAD, then compares
// chain entries in S_CMP, as the bucket-head memory and
// the entry memory are read one entry a cycle, and on a miss appends in
// S_APPEND; an emit without dedup goes straight to S_APPEND, a new trace to
// S_DONE. A stalled output holds the result in S_DONE before the next item.
// The next item is accepted while the last result still waits to be taken.
module cse_instruction_table_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic [6:0]               opcode,
    input  logic [3:0]               result_type,
    input  logic [cte_pkg::REF_W-1:0] operand_a,
    input  logic [cte_pkg::REF_W-1:0] operand_b,
    input  logic                     dedup_enable,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [cte_pkg::REF_W-1:0] reference,
    output logic                     reused,
    output logic                     store_full
);

    import cte_pkg::*;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [BUCKETS-1:0]     head_valid_reg, head_valid_next;
    logic                   out_valid_reg, out_valid_next;

    logic [6:0]             op_reg, op_next;
    logic [3:0]             rtype_reg, rtype_next;
    logic [REF_W-1:0]       a_reg, a_next;
    logic [REF_W-1:0]       b_reg, b_next;
    logic                   dedup_reg, dedup_next;
    logic [BUCKET_AW-1:0]   hash_reg, hash_next;
    logic [REF_W-1:0]       head_reg, head_next;
    logic [REF_W-1:0]       cur_ref_reg, cur_ref_next;
    logic [REF_W-1:0]       res_ref_reg, res_ref_next;
    logic                   res_reused_reg, res_reused_next;
    logic                   res_full_reg, res_full_next;
    logic [REF_W-1:0]       out_ref_reg, out_ref_next;
    logic                   out_reused_reg, out_reused_next;
    logic                   out_full_reg, out_full_next;

    logic                   bh_we;
    logic [BUCKET_AW-1:0]   bh_waddr;
    logic [REF_W-1:0]       bh_wdata;
    logic [BUCKET_AW-1:0]   bh_raddr;
    logic [REF_W-1:0]       bh_rdata;

    logic                   es_we;
    logic [ENTRY_AW-1:0]    es_waddr;
    entry_t                 es_wdata;
    logic [ENTRY_AW-1:0]    es_raddr;
    logic [ENTRY_W-1:0]     es_rdata_raw;
    entry_t                 es_rdata;

    logic [REF_W-1:0]       cand_ref;
    logic [REF_W-1:0]       cand_off;
    logic                   cand_ok;
    logic                   match;

    assign es_rdata = entry_t'(es_rdata_raw);

    cte_ram #(
        .WIDTH (REF_W),
        .DEPTH (BUCKETS)
    ) u_heads (
        .clk   (clk),
        .we    (bh_we),
        .waddr (bh_waddr),
        .wdata (bh_wdata),
        .raddr (bh_raddr),
        .rdata (bh_rdata)
    );

    cte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (es_we),
        .waddr (es_waddr),
        .wdata (es_wdata),
        .raddr (es_raddr),
        .rdata (es_rdata_raw)
    );

    // Next chain reference: bucket head on the first step, else the link.
    always_comb
    begin
        if (state_reg == S_HEAD)
        begin
            cand_ref = head_valid_reg[hash_reg] ? bh_rdata : NIL_REF;
        end
        else
        begin
            cand_ref = es_rdata.link;
        end
        cand_off = cand_ref - REF_W'(REF_BIAS);
        cand_ok  = (cand_ref != NIL_REF) &&
                   (32'(cand_off) < 32'(count_reg)) &&
                   (32'(cand_off) < 32'(CAPACITY));
        match    = (es_rdata.opcode == op_reg) &&
                   (es_rdata.operand_a == a_reg) &&
                   (es_rdata.operand_b == b_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_valid_next = head_valid_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        rtype_next      = rtype_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        dedup_next      = dedup_reg;
        hash_next       = hash_reg;
        head_next       = head_reg;
        cur_ref_next    = cur_ref_reg;
        res_ref_next    = res_ref_reg;
        res_reused_next = res_reused_reg;
        res_full_next   = res_full_reg;
        out_ref_next    = out_ref_reg;
        out_reused_next = out_reused_reg;
        out_full_next   = out_full_reg;

        bh_we    = 1'b0;
        bh_waddr = hash_reg;
        bh_wdata = REF_W'(32'(REF_BIAS) + 32'(count_reg));
        bh_raddr = bucket_of(opcode, operand_a, operand_b);

        es_we              = 1'b0;
        es_waddr           = count_reg[ENTRY_AW-1:0];
        es_wdata.opcode    = op_reg;
        es_wdata.rtype     = rtype_reg;
        es_wdata.operand_a = a_reg;
        es_wdata.operand_b = b_reg;
        es_wdata.link      = dedup_reg ? head_reg : NIL_REF;
        es_raddr           = cand_off[ENTRY_AW-1:0];

        in_stall = (state_reg != S_IDLE);

        // Drop the waiting result once taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    rtype_next      = result_type;
                    a_next          = operand_a;
                    b_next          = operand_b;
                    dedup_next      = dedup_enable;
                    hash_next       = bucket_of(opcode, operand_a, operand_b);
                    head_next       = NIL_REF;
                    res_ref_next    = NIL_REF;
                    res_reused_next = 1'b0;
                    res_full_next   = 1'b0;
                    if (func == FUNC_NEW_TRACE)
                    begin
                        count_next      = '0;
                        head_valid_next = '0;
                        state_next      = S_DONE;
                    end
                    else if (dedup_enable)
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end

            S_HEAD:
            begin
                head_next = cand_ref;
                if (cand_ok)
                begin
                    cur_ref_next = cand_ref;
                    state_next   = S_CMP;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end

            S_CMP:
            begin
                if (match)
                begin
                    res_ref_next    = cur_ref_reg;
                    res_reused_next = 1'b1;
                    state_next      = S_DONE;
                end
                else if (cand_ok)
                begin
                    cur_ref_next = cand_ref;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                if (count_reg >= COUNT_W'(CAPACITY))
                begin
                    res_full_next = 1'b1;
                end
                else
                begin
                    es_we        = 1'b1;
                    res_ref_next = bh_wdata;
                    count_next   = count_reg + COUNT_W'(1);
                    if (dedup_reg)
                    begin
                        bh_we                     = 1'b1;
                        head_valid_next[hash_reg] = 1'b1;
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_ref_next    = res_ref_reg;
                    out_reused_next = res_reused_reg;
                    out_full_next   = res_full_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            head_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        rtype_reg      <= rtype_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        dedup_reg      <= dedup_next;
        hash_reg       <= hash_next;
        head_reg       <= head_next;
        cur_ref_reg    <= cur_ref_next;
        res_ref_reg    <= res_ref_next;
        res_reused_reg <= res_reused_next;
        res_full_reg   <= res_full_next;
        out_ref_reg    <= out_ref_next;
        out_reused_reg <= out_reused_next;
        out_full_reg   <= out_full_next;
    end

    assign out_valid  = out_valid_reg;
    assign reference  = out_ref_reg;
    assign reused     = out_reused_reg;
    assign store_full = out_full_reg;

endmodule

// ----- hdl/cte_ram.sv -----
module cte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
